/* sv/mlk_pkg.sv */
// package for the morse lamp keyer: types, codes, morse table and helpers
`timescale 1ns / 1ps
`default_nettype none
package mlk_pkg;

  // default depth of the queue between classifier and sequencer
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // item kinds after classification
  localparam logic [1:0] KIND_SYM   = 2'd0;
  localparam logic [1:0] KIND_SPACE = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  // configuration register indexes
  localparam logic [7:0] REG_DOT_LENGTH      = 8'd0;
  localparam logic [7:0] REG_DASH_LENGTH     = 8'd1;
  localparam logic [7:0] REG_WORD_GAP_LENGTH = 8'd2;
  localparam logic [7:0] REG_ON_LEVEL        = 8'd3;

  localparam int unsigned NUM_SYMBOLS = 36;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  // element bits, first element in the highest used bit; 1 = dot, 0 = dash
  localparam logic [4:0] MORSE_BITS [NUM_SYMBOLS] = '{
    5'h02, 5'h07, 5'h05, 5'h03, 5'h01, 5'h0D, 5'h01, 5'h0F, 5'h03, 5'h08, 5'h02, 5'h0B,
    5'h00, 5'h01, 5'h00, 5'h09, 5'h02, 5'h05, 5'h07, 5'h00, 5'h06, 5'h0E, 5'h04, 5'h06,
    5'h04, 5'h03,
    5'h00, 5'h10, 5'h18, 5'h1C, 5'h1E, 5'h1F, 5'h0F, 5'h07, 5'h03, 5'h01
  };

  localparam logic [2:0] MORSE_LEN [NUM_SYMBOLS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // classified item: kind, element count, elements left-aligned in bits[4]
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] len;
    logic [4:0] bits;
  } sym_t;

  // configuration registers as seen by the sequencer
  typedef struct packed {
    logic [15:0] dot_length;
    logic [15:0] dash_length;
    logic [15:0] word_gap_length;
    logic [15:0] on_level;
  } cfg_t;

  // map one ascii byte to its kind and morse elements
  function automatic sym_t classify(input logic [7:0] ch);
    sym_t       s;
    logic [5:0] idx;
    logic [4:0] raw;
    logic [2:0] sh;
    s   = '0;
    idx = '0;
    if (ch inside {[8'h61:8'h7A]}) begin
      idx = 6'(ch - 8'h61);
    end else begin
      idx = 6'(ch - 8'h30 + 8'd26);
    end
    if ((ch inside {[8'h61:8'h7A]}) || (ch inside {[8'h30:8'h39]})) begin
      raw    = MORSE_BITS[idx];
      s.len  = MORSE_LEN[idx];
      sh     = 3'd5 - s.len;
      s.bits = raw << sh;
      s.kind = KIND_SYM;
    end else if (ch == ASCII_SPACE) begin
      s.kind = KIND_SPACE;
    end else begin
      s.kind = KIND_OTHER;
    end
    return s;
  endfunction

  // a zero duration register counts as one tick
  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage
`default_nettype wire

/* sv/morse_lamp_keyer_unit.sv */
// top level of the morse lamp keyer: config registers, front end, queue, back end
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_character[7:0]
//  out     | output    | out_valid / out_ready  | out_lamp_level, out_duration, out_last
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index[7:0], cfg_wdata[15:0]
//
// a letter or digit of n elements gives 2n+1 segments, one per cycle while out_ready
// is high, after the sequencer loads the item; a space or other byte gives one segment.
// the front end register and the queue keep taking items while segments drain, until full.
// rst_n is synchronous; it empties the pipeline and loads the register defaults.
// a stalled out_ready holds the current segment and pauses the sequencer only.
`timescale 1ns / 1ps
`default_nettype none
module morse_lamp_keyer_unit #(
  parameter int unsigned QUEUE_DEPTH = mlk_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_character,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_lamp_level,
  output logic [15:0]      out_duration,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  mlk_pkg::cfg_t cfg_r;
  mlk_pkg::sym_t front_data, queue_data;
  logic          front_valid, front_ready, queue_valid, queue_ready;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_length      <= 16'd300;
      cfg_r.dash_length     <= 16'd900;
      cfg_r.word_gap_length <= 16'd6300;
      cfg_r.on_level        <= 16'd131;
    end else if (cfg_valid) begin
      case (cfg_index)
        mlk_pkg::REG_DOT_LENGTH:      cfg_r.dot_length      <= cfg_wdata;
        mlk_pkg::REG_DASH_LENGTH:     cfg_r.dash_length     <= cfg_wdata;
        mlk_pkg::REG_WORD_GAP_LENGTH: cfg_r.word_gap_length <= cfg_wdata;
        mlk_pkg::REG_ON_LEVEL:        cfg_r.on_level        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // classify incoming characters
  mlk_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .sym_valid    (front_valid),
    .sym_ready    (front_ready),
    .sym_data     (front_data)
  );

  // decouple front end from sequencer
  mlk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_data),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_data  (queue_data)
  );

  // emit timed segments
  mlk_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .sym_valid      (queue_valid),
    .sym_ready      (queue_ready),
    .sym_data       (queue_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_lamp_level (out_lamp_level),
    .out_duration   (out_duration),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

/* sv/mlk_front.sv */
// front end: accepts characters and registers their classification
`timescale 1ns / 1ps
`default_nettype none
module mlk_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_character,
  output logic               sym_valid,
  input  wire logic          sym_ready,
  output mlk_pkg::sym_t      sym_data
);

  logic          valid_r, valid_nxt;
  mlk_pkg::sym_t data_r;

  // one register stage; refills while its item drains
  assign in_ready  = !valid_r || sym_ready;
  assign sym_valid = valid_r;
  assign sym_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= mlk_pkg::classify(in_character);
    end
  end

endmodule
`default_nettype wire

/* sv/mlk_queue.sv */
// small queue of classified items between front end and sequencer
`timescale 1ns / 1ps
`default_nettype none
module mlk_queue #(
  parameter int unsigned DEPTH = mlk_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire mlk_pkg::sym_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output mlk_pkg::sym_t      rd_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mlk_pkg::sym_t  mem_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push, pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointer and fill count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

/* sv/mlk_back.sv */
// back end: steps through the elements of one item and emits lamp segments
`timescale 1ns / 1ps
`default_nettype none
module mlk_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mlk_pkg::cfg_t cfg,
  input  wire logic          sym_valid,
  output logic               sym_ready,
  input  wire mlk_pkg::sym_t sym_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        out_lamp_level,
  output logic [15:0]        out_duration,
  output logic               out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LIT  = 2'd1;
  localparam logic [1:0] ST_GAP  = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [4:0]  bits_r, bits_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] level_r, level_nxt;
  logic [15:0] dur_r, dur_nxt;
  logic        last_r, last_nxt;
  logic        slot_free;
  logic [15:0] dot, dash, gap;

  assign dot       = mlk_pkg::at_least_one(cfg.dot_length);
  assign dash      = mlk_pkg::at_least_one(cfg.dash_length);
  assign gap       = mlk_pkg::at_least_one(cfg.word_gap_length);
  assign slot_free = !out_valid_r || out_ready;
  assign sym_ready = (state_r == ST_IDLE);

  assign out_valid      = out_valid_r;
  assign out_lamp_level = level_r;
  assign out_duration   = dur_r;
  assign out_last       = last_r;

  // segment sequencer
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cnt_nxt       = cnt_r;
    bits_nxt      = bits_r;
    out_valid_nxt = out_valid_r && !out_ready;
    level_nxt     = level_r;
    dur_nxt       = dur_r;
    last_nxt      = last_r;
    case (state_r)
      ST_IDLE: begin
        if (sym_valid) begin
          kind_nxt  = sym_data.kind;
          cnt_nxt   = sym_data.len;
          bits_nxt  = sym_data.bits;
          state_nxt = (sym_data.kind == mlk_pkg::KIND_SYM) ? ST_LIT : ST_END;
        end
      end
      ST_LIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          level_nxt     = cfg.on_level;
          dur_nxt       = bits_r[4] ? dot : dash;
          last_nxt      = 1'b0;
          bits_nxt      = {bits_r[3:0], 1'b0};
          cnt_nxt       = cnt_r - 1'b1;
          state_nxt     = ST_GAP;
        end
      end
      ST_GAP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          level_nxt     = 16'd0;
          dur_nxt       = dot;
          last_nxt      = 1'b0;
          state_nxt     = (cnt_r == 3'd0) ? ST_END : ST_LIT;
        end
      end
      ST_END: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          level_nxt     = 16'd0;
          dur_nxt       = (kind_r == mlk_pkg::KIND_SPACE) ? gap : dot;
          last_nxt      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and output payload
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    cnt_r   <= cnt_nxt;
    bits_r  <= bits_nxt;
    level_r <= level_nxt;
    dur_r   <= dur_nxt;
    last_r  <= last_nxt;
  end

endmodule
`default_nettype wire
